### hdl/tw_odo_pkg.sv
// ----------------------------------------------------------------------------
// tw_odo_pkg
// shared types, constants and the arctangent table of the odometry block
// ----------------------------------------------------------------------------
`default_nettype none
package tw_odo_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_W     = 34;
  localparam int TRIG_W       = 24;
  localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032874;
  localparam logic [23:0] DPC_RESET = 24'd386039;
  localparam logic [31:0] HPC_RESET = 32'd1451845222;
  localparam logic [7:0]  REG_DPC   = 8'd0;
  localparam logic [7:0]  REG_HPC   = 8'd1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MULF, ST_MULL, ST_MULH, ST_CORD, ST_ROUND, ST_MAC, ST_COMMIT
  } state_t;

  typedef enum logic [1:0] {MUL_F, MUL_L, MUL_H} mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     trig_round;
    logic     mac_start;
    logic     mac_step;
    logic     commit;
  } cmd_t;

  typedef struct packed {
    logic primed;
    logic cordic_done;
    logic mac_done;
    logic out_busy;
  } status_t;

  function automatic logic signed [CORDIC_W-1:0] atan_lut(input logic [4:0] i);
    logic signed [CORDIC_W-1:0] v;
    unique case (i)
      5'd0:  v = 34'sh20000000;
      5'd1:  v = 34'sh12E4051E;
      5'd2:  v = 34'sh09FB385B;
      5'd3:  v = 34'sh051111D4;
      5'd4:  v = 34'sh028B0D43;
      5'd5:  v = 34'sh0145D7E1;
      5'd6:  v = 34'sh00A2F61E;
      5'd7:  v = 34'sh00517C55;
      5'd8:  v = 34'sh0028BE53;
      5'd9:  v = 34'sh00145F2F;
      5'd10: v = 34'sh000A2F98;
      5'd11: v = 34'sh000517CC;
      5'd12: v = 34'sh00028BE6;
      5'd13: v = 34'sh000145F3;
      5'd14: v = 34'sh0000A2FA;
      5'd15: v = 34'sh0000517D;
      5'd16: v = 34'sh000028BE;
      5'd17: v = 34'sh0000145F;
      5'd18: v = 34'sh00000A30;
      5'd19: v = 34'sh00000518;
      5'd20: v = 34'sh0000028C;
      5'd21: v = 34'sh00000146;
      5'd22: v = 34'sh000000A3;
      5'd23: v = 34'sh00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### hdl/tw_odo_ctrl.sv
// ----------------------------------------------------------------------------
// tw_odo_ctrl
// sequencer that steps the odometry datapath through one sample
// ----------------------------------------------------------------------------
`default_nettype none
module tw_odo_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  tw_odo_pkg::status_t status,
  output tw_odo_pkg::cmd_t    cmd
);
  import tw_odo_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid && status.primed) state_nxt = ST_MULF;
      ST_MULF:   state_nxt = ST_MULL;
      ST_MULL:   state_nxt = ST_MULH;
      ST_MULH:   state_nxt = ST_CORD;
      ST_CORD:   if (status.cordic_done) state_nxt = ST_ROUND;
      ST_ROUND:  state_nxt = ST_MAC;
      ST_MAC:    if (status.mac_done) state_nxt = ST_COMMIT;
      ST_COMMIT: if (!status.out_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mul_sel = MUL_F;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_MULF: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MUL_F;
      end
      ST_MULL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MUL_L;
      end
      ST_MULH: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MUL_H;
      end
      ST_CORD: ;
      ST_ROUND: begin
        cmd.trig_round = 1'b1;
        cmd.mac_start  = 1'b1;
      end
      ST_MAC:    cmd.mac_step = 1'b1;
      ST_COMMIT: cmd.commit = !status.out_busy;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### hdl/tw_odo_dp.sv
// ----------------------------------------------------------------------------
// tw_odo_dp
// deltas, shared multiplier, cordic rotation and pose accumulators
// ----------------------------------------------------------------------------
`default_nettype none
module tw_odo_dp #(
  parameter int COUNT_WIDTH    = 16,
  parameter int POSITION_WIDTH = 48
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  tw_odo_pkg::cmd_t                 cmd,
  output tw_odo_pkg::status_t              status,
  input  wire  [COUNT_WIDTH-1:0]           side_a_count,
  input  wire  [COUNT_WIDTH-1:0]           lateral_count,
  input  wire  [COUNT_WIDTH-1:0]           side_b_count,
  input  wire                              cfg_we,
  input  wire  [7:0]                       cfg_index,
  input  wire  [31:0]                      cfg_data,
  input  wire                              out_tready,
  output logic                             out_tvalid,
  output logic [POSITION_WIDTH-1:0]        x_position,
  output logic [POSITION_WIDTH-1:0]        y_position,
  output logic [31:0]                      heading
);
  import tw_odo_pkg::*;

  localparam int CW    = COUNT_WIDTH;
  localparam int PW    = POSITION_WIDTH;
  localparam int FW    = CW + 27;
  localparam int MA    = (CW + 2 > 33) ? CW + 2 : 33;
  localparam int MB    = 33;
  localparam int PRODW = MA + MB;
  localparam int AW    = PW + 29;

  logic [23:0] dpc_r;
  logic [31:0] hpc_r;
  logic [CW-1:0] prev_a_r, prev_l_r, prev_b_r;
  logic primed_r;
  logic signed [CW-1:0] da_r, dl_r, db_r;
  logic signed [FW-1:0] f_r, l_r;
  logic [31:0] dh_r;
  logic [PW-1:0] pose_x_r, pose_y_r;
  logic [31:0] pose_h_r;
  logic out_valid_r;

  logic signed [CORDIC_W-1:0] cx_r, cy_r, cz_r;
  logic [4:0] it_r;
  logic flip_r;
  logic signed [TRIG_W-1:0] c_r, s_r, ns_r;
  logic [3:0] cnt_r;
  logic signed [PRODW-1:0] prod_r;
  logic [AW-1:0] accx_r, accy_r;

  // deltas
  logic [CW-1:0] cur_a;
  logic signed [CW-1:0] da, dl, db;
  assign cur_a = CW'(0) - side_a_count;
  assign da = cur_a - prev_a_r;
  assign dl = lateral_count - prev_l_r;
  assign db = side_b_count - prev_b_r;

  // shared multiplier operands
  logic signed [CW+1:0] negsum, twol, hdiff;
  logic signed [MA-1:0] opa;
  logic signed [MB-1:0] opb;
  logic signed [PRODW-1:0] prod;
  logic [2:0] k;
  logic signed [MA-1:0] f_lo, f_hi, l_lo, l_hi;
  logic signed [TRIG_W-1:0] tsel;
  logic [47:0] hsum;

  assign negsum = -({{2{da_r[CW-1]}}, da_r} + {{2{db_r[CW-1]}}, db_r});
  assign twol   = {dl_r[CW-1], dl_r, 1'b0};
  assign hdiff  = {{2{db_r[CW-1]}}, db_r} - {{2{da_r[CW-1]}}, da_r};
  assign f_lo = {{(MA-32){1'b0}}, f_r[31:0]};
  assign f_hi = {{(MA-FW+32){f_r[FW-1]}}, f_r[FW-1:32]};
  assign l_lo = {{(MA-32){1'b0}}, l_r[31:0]};
  assign l_hi = {{(MA-FW+32){l_r[FW-1]}}, l_r[FW-1:32]};
  assign k = cnt_r[2:0];

  always_comb begin
    opa = '0;
    opb = '0;
    tsel = c_r;
    if (cmd.mul_en) begin
      unique case (cmd.mul_sel)
        MUL_F: begin
          opa = {{(MA-CW-2){negsum[CW+1]}}, negsum};
          opb = {9'd0, dpc_r};
        end
        MUL_L: begin
          opa = {{(MA-CW-2){twol[CW+1]}}, twol};
          opb = {9'd0, dpc_r};
        end
        MUL_H: begin
          opa = {{(MA-CW-2){hdiff[CW+1]}}, hdiff};
          opb = {1'b0, hpc_r};
        end
        default: ;
      endcase
    end else begin
      // x: f*c then l*(-s); y: f*s then l*c
      unique case (k[2:1])
        2'd0: tsel = c_r;
        2'd1: tsel = ns_r;
        2'd2: tsel = s_r;
        2'd3: tsel = c_r;
        default: tsel = c_r;
      endcase
      if (k[1]) begin
        opa = k[0] ? l_hi : l_lo;
      end else begin
        opa = k[0] ? f_hi : f_lo;
      end
      opb = {{(MB-TRIG_W){tsel[TRIG_W-1]}}, tsel};
    end
  end

  assign prod = opa * opb;
  assign hsum = prod[47:0] + 48'h8000;

  // cordic
  logic [31:0] u;
  logic ang_flip;
  logic signed [CORDIC_W-1:0] xs, ys, at;
  logic signed [CORDIC_W-1:0] xrnd, yrnd;
  logic signed [TRIG_W-1:0] cv, sv;
  assign ang_flip = pose_h_r[31] ^ pose_h_r[30];
  assign u  = ang_flip ? (pose_h_r ^ 32'h8000_0000) : pose_h_r;
  assign xs = cx_r >>> it_r;
  assign ys = cy_r >>> it_r;
  assign at = atan_lut(it_r);
  assign xrnd = cx_r + 34'sd512;
  assign yrnd = cy_r + 34'sd512;
  assign cv = flip_r ? -xrnd[33:10] : xrnd[33:10];
  assign sv = flip_r ? -yrnd[33:10] : yrnd[33:10];

  // accumulation of registered products
  logic [PRODW+AW-1:0] pext, pshift;
  logic [2:0] kp;
  assign pext   = {{AW{prod_r[PRODW-1]}}, prod_r};
  assign kp     = 3'(cnt_r - 4'd1);
  assign pshift = kp[0] ? (pext << 32) : pext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dpc_r       <= DPC_RESET;
      hpc_r       <= HPC_RESET;
      prev_a_r    <= '0;
      prev_l_r    <= '0;
      prev_b_r    <= '0;
      primed_r    <= 1'b0;
      pose_x_r    <= '0;
      pose_y_r    <= '0;
      pose_h_r    <= '0;
      out_valid_r <= 1'b0;
      it_r        <= 5'(CORDIC_STEPS);
      cnt_r       <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_DPC) dpc_r <= cfg_data[23:0];
      if (cfg_we && cfg_index == REG_HPC) hpc_r <= cfg_data;
      if (cmd.load) begin
        prev_a_r <= cur_a;
        prev_l_r <= lateral_count;
        prev_b_r <= side_b_count;
        primed_r <= 1'b1;
        it_r     <= '0;
      end else if (it_r != 5'(CORDIC_STEPS)) begin
        it_r <= it_r + 5'd1;
      end
      if (cmd.mac_start) begin
        cnt_r <= '0;
      end else if (cmd.mac_step && cnt_r != 4'd9) begin
        cnt_r <= cnt_r + 4'd1;
      end
      if (cmd.commit) begin
        pose_x_r    <= pose_x_r + accx_r[AW-1:29];
        pose_y_r    <= pose_y_r + accy_r[AW-1:29];
        pose_h_r    <= pose_h_r + dh_r;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      da_r   <= da;
      dl_r   <= dl;
      db_r   <= db;
      cx_r   <= CORDIC_START;
      cy_r   <= '0;
      cz_r   <= {{2{u[31]}}, u};
      flip_r <= ang_flip;
    end else if (it_r != 5'(CORDIC_STEPS)) begin
      if (!cz_r[CORDIC_W-1]) begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - at;
      end else begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + at;
      end
    end
    if (cmd.mul_en && cmd.mul_sel == MUL_F) f_r <= prod[FW-1:0];
    if (cmd.mul_en && cmd.mul_sel == MUL_L) l_r <= prod[FW-1:0];
    if (cmd.mul_en && cmd.mul_sel == MUL_H) dh_r <= hsum[47:16];
    if (cmd.trig_round) begin
      c_r  <= cv;
      s_r  <= sv;
      ns_r <= -sv;
    end
    if (cmd.mac_start) begin
      accx_r <= AW'(1) << 28;
      accy_r <= AW'(1) << 28;
    end else if (cmd.mac_step && cnt_r != 4'd9) begin
      if (cnt_r < 4'd8) prod_r <= prod;
      if (cnt_r != 4'd0) begin
        if (kp[2]) accy_r <= accy_r + pshift[AW-1:0];
        else       accx_r <= accx_r + pshift[AW-1:0];
      end
    end
  end

  assign status.primed      = primed_r;
  assign status.cordic_done = (it_r == 5'(CORDIC_STEPS));
  assign status.mac_done    = (cnt_r == 4'd9);
  assign status.out_busy    = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign x_position = pose_x_r;
  assign y_position = pose_y_r;
  assign heading    = pose_h_r;

endmodule
`default_nettype wire

### hdl/three_wheel_odometry_top.sv
// ----------------------------------------------------------------------------
// three_wheel_odometry_top
// dead reckoning from three encoder wheels, one pose word per sample
//
// in_tdata carries side_a_count, lateral_count and side_b_count. the first
// word after reset only primes the stored counts and gives no pose.
// every later word gives one pose word on out_tdata: x, y and heading.
// each sample runs 24 cordic steps on the old heading, with the three
// multiplies alongside the first steps, then the done check, the round,
// 8 partial products on the shared 33x33 multiplier and their
// accumulation, then the pose update. one sample in flight.
// the pose word sits in the output register until taken; a new sample is
// accepted meanwhile, and its update waits while out_tready is low.
// cfg writes (index 0 distance_per_count, 1 heading_per_count) are always
// taken, other indexes are dropped. synchronous reset clears the pose,
// the stored counts, the primed flag and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none
module three_wheel_odometry_top #(
  parameter int COUNT_WIDTH    = 16,
  parameter int POSITION_WIDTH = 48
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // side_a_count, lateral_count, side_b_count
  input  wire  [((3*COUNT_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  // x_position, y_position, heading
  output logic [((2*POSITION_WIDTH+32+7)/8)*8-1:0] out_tdata,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [7:0]  cfg_index,
  input  wire  [31:0] cfg_data
);
  import tw_odo_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam int PW = POSITION_WIDTH;
  localparam int OW = ((2*PW+32+7)/8)*8;

  cmd_t    cmd;
  status_t status;
  logic [PW-1:0] x_position, y_position;
  logic [31:0] heading;

  assign cfg_ready = 1'b1;

  tw_odo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  tw_odo_dp #(
    .COUNT_WIDTH    (COUNT_WIDTH),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .side_a_count  (in_tdata[CW-1:0]),
    .lateral_count (in_tdata[2*CW-1:CW]),
    .side_b_count  (in_tdata[3*CW-1:2*CW]),
    .cfg_we        (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_tready    (out_tready),
    .out_tvalid    (out_tvalid),
    .x_position    (x_position),
    .y_position    (y_position),
    .heading       (heading)
  );

  assign out_tdata = OW'({heading, y_position, x_position});

endmodule
`default_nettype wire

### tb/tb_three_wheel_odometry_top.sv
// ----------------------------------------------------------------------------
// tb_three_wheel_odometry_top
// self-checking bench for the three wheel odometry block: encoder samples go
// in through the input stream, a local pose tracker predicts every pose word
// and the output monitor compares x, y and heading in order. directed table
// first, then random motion over several register settings and idle patterns
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_three_wheel_odometry_top;
  import tw_odo_pkg::*;

  typedef struct {
    logic [47:0] x;
    logic [47:0] y;
    logic [31:0] h;
  } pose_t;

  typedef struct {
    logic [15:0] a;
    logic [15:0] l;
    logic [15:0] b;
    bit          typed;
    bit          has_pose;
    pose_t       pose;
  } sample_row_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [47:0]   in_tdata = '0;  // side_a_count, lateral_count, side_b_count
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [127:0]  out_tdata;      // x_position, y_position, heading
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [7:0]    cfg_index = '0;
  logic [31:0]   cfg_data = '0;

  three_wheel_odometry_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // tracker state
  logic [23:0] trk_dpc;
  logic [31:0] trk_hpc;
  logic [15:0] trk_prev [3];
  bit          trk_primed;
  pose_t       trk_pose;
  pose_t       pending_poses [$];
  int          n_errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  const longint atan_units [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

  // cos and sin of a binary angle, q20
  task automatic heading_trig(input logic [31:0] ang, output longint c, output longint s);
    logic [31:0] u;
    bit          flip;
    longint      x, y, z, nx;
    u = ang;
    flip = u[31] != u[30];
    if (flip) u[31] = ~u[31];
    x = 652032874;
    y = 0;
    z = longint'($signed(u));
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_units[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_units[i];
      end
      x = nx;
    end
    x = (x + 512) >>> 10;
    y = (y + 512) >>> 10;
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // advance the tracked pose by one sample, returns 1 when a pose word follows
  task automatic track_sample(input logic [15:0] a, l, b, output bit has_pose);
    logic [15:0]         cur [3];
    logic [15:0]         d16;
    longint              da, dl, db, f, lat, c, s;
    logic signed [127:0] acc;
    logic [63:0]         turn;
    cur[0] = 16'd0 - a;
    cur[1] = l;
    cur[2] = b;
    has_pose = trk_primed;
    if (trk_primed) begin
      d16 = cur[0] - trk_prev[0]; da = longint'($signed(d16));
      d16 = cur[1] - trk_prev[1]; dl = longint'($signed(d16));
      d16 = cur[2] - trk_prev[2]; db = longint'($signed(d16));
      f = -(da + db) * longint'(trk_dpc);
      lat = 2 * dl * longint'(trk_dpc);
      heading_trig(trk_pose.h, c, s);
      acc = (128'(f) * 128'(c) - 128'(lat) * 128'(s) + 128'sd268435456) >>> 29;
      trk_pose.x = trk_pose.x + acc[47:0];
      acc = (128'(f) * 128'(s) + 128'(lat) * 128'(c) + 128'sd268435456) >>> 29;
      trk_pose.y = trk_pose.y + acc[47:0];
      turn = (db - da) * longint'(trk_hpc) + 64'h8000;
      trk_pose.h = trk_pose.h + turn[47:16];
    end
    trk_primed = 1'b1;
    for (int k = 0; k < 3; k++) trk_prev[k] = cur[k];
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_DPC) trk_dpc = val[23:0];
    else if (idx == REG_HPC) trk_hpc = val;
  endtask

  task automatic send_word(input sample_row_t row);
    bit has_pose;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {row.b, row.l, row.a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_sample(row.a, row.l, row.b, has_pose);
    if (row.typed) begin
      if (row.has_pose) pending_poses.push_back(row.pose);
    end else if (has_pose) begin
      pending_poses.push_back(trk_pose);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    pose_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_poses.size() == 0) begin
        $error("unexpected pose word %h", out_tdata);
        n_errors++;
      end else begin
        want = pending_poses.pop_front();
        if (out_tdata[47:0] !== want.x) begin
          $error("x_position exp %h got %h", want.x, out_tdata[47:0]);
          n_errors++;
        end
        if (out_tdata[95:48] !== want.y) begin
          $error("y_position exp %h got %h", want.y, out_tdata[95:48]);
          n_errors++;
        end
        if (out_tdata[127:96] !== want.h) begin
          $error("heading exp %h got %h", want.h, out_tdata[127:96]);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("tb_three_wheel_odometry_top NOT OK");
    $finish;
  end

  initial begin
    sample_row_t dir_rows [$];
    sample_row_t row;
    pose_t       zero_pose;
    logic [15:0] cnt [3];
    int          mode;
    trk_dpc = DPC_RESET;
    trk_hpc = HPC_RESET;
    trk_primed = 1'b0;
    trk_pose = '{x: '0, y: '0, h: '0};
    zero_pose = trk_pose;
    for (int k = 0; k < 3; k++) trk_prev[k] = '0;

    // a, l, b, typed, has_pose, pose
    dir_rows = '{
      '{16'h0000, 16'h0000, 16'h0000, 1, 0, zero_pose},  // priming word
      '{16'h0000, 16'h0000, 16'h0000, 1, 1, zero_pose},  // no motion
      '{16'h8000, 16'h0000, 16'h0000, 0, 0, zero_pose},  // negation wraps
      '{16'h8000, 16'h0000, 16'h0000, 0, 0, zero_pose},
      '{16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, zero_pose},
      '{16'h8000, 16'h8000, 16'h8000, 0, 0, zero_pose},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, zero_pose},
      '{16'h0000, 16'h0000, 16'h0000, 0, 0, zero_pose},
      '{16'h0000, 16'h0064, 16'h0000, 0, 0, zero_pose},  // lateral only
      '{16'hFF9C, 16'h0064, 16'h0000, 0, 0, zero_pose},  // side a only
      '{16'hFF9C, 16'h0064, 16'h0064, 0, 0, zero_pose},  // side b only
      '{16'hFF00, 16'h0100, 16'h0200, 0, 0, zero_pose},
      '{16'h7FFF, 16'h8000, 16'h7FFF, 0, 0, zero_pose},
      '{16'h8001, 16'h7FFF, 16'h8001, 0, 0, zero_pose},
      '{16'h1234, 16'hABCD, 16'h5A5A, 0, 0, zero_pose}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_word(dir_rows[i]);
    drain();

    cnt[0] = 16'h1234; cnt[1] = 16'hABCD; cnt[2] = 16'h5A5A;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      case (phase)
        0: begin write_reg(REG_DPC, 32'hFFFFFFFF); write_reg(REG_HPC, 32'hFFFFFFFF); end
        1: begin write_reg(REG_DPC, 32'h0);        write_reg(REG_HPC, 32'h0);        end
        2: begin write_reg(REG_DPC, 32'(DPC_RESET)); write_reg(REG_HPC, HPC_RESET);  end
        3: begin write_reg(REG_DPC, 32'h1);        write_reg(REG_HPC, 32'h10000);    end
        default: begin
          write_reg(REG_DPC, $urandom());
          write_reg(REG_HPC, $urandom());
        end
      endcase
      write_reg(8'(2 + $urandom_range(253)), $urandom());  // dropped index
      for (int n = 0; n < 155; n++) begin
        mode = $urandom_range(99);
        for (int k = 0; k < 3; k++) begin
          if (mode < 70) cnt[k] = cnt[k] + 16'($signed($urandom_range(400)) - 200);
          else if (mode < 90) cnt[k] = 16'($urandom());
          else cnt[k] = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
        end
        row = '{cnt[0], cnt[1], cnt[2], 0, 0, zero_pose};
        send_word(row);
      end
      drain();
    end

    if (n_errors == 0) begin
      $display("tb_three_wheel_odometry_top OK");
    end else begin
      $display("tb_three_wheel_odometry_top NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

### three_wheel_odometry_top.f
hdl/tw_odo_pkg.sv
hdl/tw_odo_ctrl.sv
hdl/tw_odo_dp.sv
hdl/three_wheel_odometry_top.sv
tb/tb_three_wheel_odometry_top.sv
